[hdl/osma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osma_pkg
// Shared widths, codes and helpers for the semi-major axis unit.
// ----------------------------------------------------------------------------
package osma_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;

    localparam int REG_W   = 31;                          // config registers
    localparam int DIFF_W  = WORD_WIDTH + 1;              // component difference
    localparam int MSUM_W  = WORD_WIDTH + 1;              // inner mass sum
    localparam int MTOT_W  = WORD_WIDTH + 2;              // total mass
    localparam int SQ_W    = 2 * WORD_WIDTH + 2;          // sum of three squares
    localparam int ROOT_W  = (SQ_W + 1) / 2;              // isqrt result
    localparam int REM_W   = ROOT_W + 3;                  // isqrt remainder
    localparam int GM_W    = 2 * WORD_WIDTH;              // G*M, Q2F
    localparam int K_W     = SQ_W - FRAC_BITS - 1;        // kinetic term
    localparam int OUT_W   = 48;
    localparam int BIT_CW  = $clog2(WORD_WIDTH);
    localparam int RCNT_W  = $clog2(ROOT_W);
    localparam int DCNT_W  = $clog2(GM_W);
    localparam int GCNT_W  = $clog2(REG_W);

    typedef enum logic [2:0] {
        OP_STORE_FIRST = 3'd0,
        OP_INNER_CALC  = 3'd1,
        OP_OUTER_IN1   = 3'd2,
        OP_OUTER_IN2   = 3'd3,
        OP_OUTER_CALC  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MASS  = 2'd1,
        ST_TOO_CLOSE = 2'd2,
        ST_UNBOUND   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_GRAV   = 2'd0,
        CFG_MINDST = 2'd1,
        CFG_MARGIN = 2'd2
    } cfg_idx_t;

    // magnitude of a difference; never exceeds 2^WORD_WIDTH - 1
    function automatic logic [WORD_WIDTH-1:0] mag(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] t;
        t = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
        return t[WORD_WIDTH-1:0];
    endfunction

endpackage

[hdl/osma_sqacc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osma_sqacc
// Bit-serial sum of three squares, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module osma_sqacc (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [osma_pkg::DIFF_W-1:0]       d0,
    input  logic [osma_pkg::DIFF_W-1:0]       d1,
    input  logic [osma_pkg::DIFF_W-1:0]       d2,
    output logic                              done,
    output logic [osma_pkg::SQ_W-1:0]         sum
);
    logic                                busy_reg, done_reg;
    logic [osma_pkg::SQ_W-1:0]           acc_reg, mcand_reg;
    logic [osma_pkg::WORD_WIDTH-1:0]     mplier_reg, mag1_reg, mag2_reg;
    logic [osma_pkg::BIT_CW-1:0]         bit_reg;
    logic [1:0]                          elem_reg;
    logic                                bit_last, last;

    assign bit_last = (bit_reg == osma_pkg::BIT_CW'(osma_pkg::WORD_WIDTH - 1));
    assign last     = bit_last && (elem_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= osma_pkg::SQ_W'(osma_pkg::mag(d0));
            mplier_reg <= osma_pkg::mag(d0);
            mag1_reg   <= osma_pkg::mag(d1);
            mag2_reg   <= osma_pkg::mag(d2);
            bit_reg    <= '0;
            elem_reg   <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            if (bit_last) begin
                // next component
                mcand_reg  <= osma_pkg::SQ_W'(mag1_reg);
                mplier_reg <= mag1_reg;
                mag1_reg   <= mag2_reg;
                bit_reg    <= '0;
                elem_reg   <= elem_reg + 2'd1;
            end else begin
                mcand_reg  <= {mcand_reg[osma_pkg::SQ_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[osma_pkg::WORD_WIDTH-1:1]};
                bit_reg    <= bit_reg + osma_pkg::BIT_CW'(1);
            end
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

[hdl/osma_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osma_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module osma_isqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [osma_pkg::SQ_W-1:0]         radicand,
    output logic                              done,
    output logic [osma_pkg::ROOT_W-1:0]       root
);
    localparam int RAD_W = 2 * osma_pkg::ROOT_W;

    logic                              busy_reg, done_reg;
    logic [RAD_W-1:0]                  rad_reg;
    logic [osma_pkg::REM_W-1:0]        rem_reg, rem_sh, trial;
    logic [osma_pkg::ROOT_W-1:0]       root_reg;
    logic [osma_pkg::RCNT_W-1:0]       cnt_reg;
    logic                              last, fits;

    assign last   = (cnt_reg == osma_pkg::RCNT_W'(osma_pkg::ROOT_W - 1));
    assign rem_sh = {rem_reg[osma_pkg::REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = osma_pkg::REM_W'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[osma_pkg::ROOT_W-2:0], fits};
            cnt_reg  <= cnt_reg + osma_pkg::RCNT_W'(1);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/osma_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osma_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [osma_pkg::GM_W-1:0]         dividend,
    input  logic [osma_pkg::GM_W-1:0]         divisor,
    output logic                              busy,
    output logic                              done,
    output logic [osma_pkg::GM_W-1:0]         quotient
);
    localparam int W = osma_pkg::GM_W;

    logic                         busy_reg, done_reg;
    logic [W-1:0]                 quo_reg, dsr_reg;
    logic [W:0]                   rem_reg, rem_sh;
    logic [osma_pkg::DCNT_W-1:0]  cnt_reg;
    logic                         last, fits;

    assign last   = (cnt_reg == osma_pkg::DCNT_W'(W - 1));
    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign fits   = (rem_sh >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // dividend bits leave at the top of quo_reg as quotient bits enter below
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            quo_reg <= {quo_reg[W-2:0], fits};
            cnt_reg <= cnt_reg + osma_pkg::DCNT_W'(1);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/orbit_semi_major_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_semi_major_axis
// Vis-viva semi-major axis a = G*M / (2*(G*M/r - v^2/2)), bit-serial datapath.
// ----------------------------------------------------------------------------
// Sequence: store ops leave the unit idle. A bad-mass item goes from S_IDLE to S_OUT,
//   which raises m_valid; otherwise the item passes the squares, the root and the
//   divides; a too-close or unbound result ends earlier.
// Throughput: one compute item at a time; s_ready returns with m_valid, so the
//   next transfer waits for a full computation. The squaring, root and division
//   loops run one bit per cycle and set how long a computation takes.
// Reset: synchronous active-low; registers to defaults, stored particle zero.
// ----------------------------------------------------------------------------
module orbit_semi_major_axis (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_op,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_pos_x,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_pos_y,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_pos_z,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_vel_x,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_vel_y,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_vel_z,
    input  logic signed [osma_pkg::WORD_WIDTH-1:0] s_mass,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [osma_pkg::OUT_W-1:0]        m_semi_major_axis,
    output logic [1:0]                        m_status
);
    localparam int W = osma_pkg::WORD_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_DIV1 = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [osma_pkg::REG_W-1:0] grav_reg, mindst_reg, margin_reg;

    // particle state
    logic [W-1:0] st_px_reg, st_py_reg, st_pz_reg;
    logic [W-1:0] st_vx_reg, st_vy_reg, st_vz_reg, st_m_reg;
    logic [osma_pkg::MSUM_W-1:0] msum_reg, msum_next;
    logic                        mok_reg;

    // handshake / op decode
    logic s_xfer, is_inner, is_outer, is_calc, bad_mass;
    logic m_pos, s_m_pos, st_m_pos, msum_pos;
    logic [osma_pkg::MTOT_W-1:0] mtot;
    logic [osma_pkg::DIFF_W-1:0] dpx, dpy, dpz, dvx, dvy, dvz;

    // G*M serial multiply
    logic                         gm_busy_reg;
    logic [osma_pkg::GM_W-1:0]    gm_reg, gm_mcand_reg;
    logic [osma_pkg::REG_W-1:0]   gm_mplier_reg;
    logic [osma_pkg::GCNT_W-1:0]  gm_cnt_reg;

    // sub-units
    logic                         sq_start, pos_done, vel_done;
    logic [osma_pkg::SQ_W-1:0]    sr_sum, sv_sum;
    logic                         rt_start, rt_done;
    logic [osma_pkg::ROOT_W-1:0]  root;
    logic                         dv_start, dv_busy, dv_done;
    logic [osma_pkg::GM_W-1:0]    dv_divisor, quotient;

    // energy compare
    logic [osma_pkg::GM_W-1:0]    p_reg;
    logic [osma_pkg::GM_W-1:0]    k_ext;
    logic [osma_pkg::GM_W:0]      k_marg;
    logic                         too_close, unbound;

    // result
    logic [osma_pkg::OUT_W-1:0]   sma_reg, sma_next;
    logic [1:0]                   status_reg;
    logic                         m_valid_reg;

    // ------------------------------------------------------------------
    // configuration port: always ready; the sender writes only when idle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg   <= osma_pkg::REG_W'(65536);
            mindst_reg <= osma_pkg::REG_W'(1);
            margin_reg <= osma_pkg::REG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                osma_pkg::CFG_GRAV:   grav_reg   <= cfg_data[osma_pkg::REG_W-1:0];
                osma_pkg::CFG_MINDST: mindst_reg <= cfg_data[osma_pkg::REG_W-1:0];
                osma_pkg::CFG_MARGIN: margin_reg <= cfg_data[osma_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode: differences, mass checks and total mass, all parallel
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign is_inner = (s_op == osma_pkg::OP_INNER_CALC);
    assign is_outer = (s_op == osma_pkg::OP_OUTER_CALC);
    assign is_calc  = is_inner || is_outer;

    assign s_m_pos  = !s_mass[W-1] && (s_mass != '0);
    assign st_m_pos = !st_m_reg[W-1] && (st_m_reg != '0);
    assign msum_pos = !msum_reg[osma_pkg::MSUM_W-1] && (msum_reg != '0);
    assign m_pos    = s_m_pos;

    assign bad_mass = is_inner ? (!st_m_pos || !m_pos)
                               : (!mok_reg || !msum_pos || !m_pos);

    // both terms positive here, so zero extension is exact
    assign mtot = is_inner
        ? osma_pkg::MTOT_W'(st_m_reg) + osma_pkg::MTOT_W'(s_mass)
        : osma_pkg::MTOT_W'(msum_reg) + osma_pkg::MTOT_W'(s_mass);

    // inner mode uses relative motion, outer mode the particle itself
    assign dpx = is_inner ? ($signed({s_pos_x[W-1], s_pos_x}) - $signed({st_px_reg[W-1], st_px_reg}))
                          : {s_pos_x[W-1], s_pos_x};
    assign dpy = is_inner ? ($signed({s_pos_y[W-1], s_pos_y}) - $signed({st_py_reg[W-1], st_py_reg}))
                          : {s_pos_y[W-1], s_pos_y};
    assign dpz = is_inner ? ($signed({s_pos_z[W-1], s_pos_z}) - $signed({st_pz_reg[W-1], st_pz_reg}))
                          : {s_pos_z[W-1], s_pos_z};
    assign dvx = is_inner ? ($signed({s_vel_x[W-1], s_vel_x}) - $signed({st_vx_reg[W-1], st_vx_reg}))
                          : {s_vel_x[W-1], s_vel_x};
    assign dvy = is_inner ? ($signed({s_vel_y[W-1], s_vel_y}) - $signed({st_vy_reg[W-1], st_vy_reg}))
                          : {s_vel_y[W-1], s_vel_y};
    assign dvz = is_inner ? ($signed({s_vel_z[W-1], s_vel_z}) - $signed({st_vz_reg[W-1], st_vz_reg}))
                          : {s_vel_z[W-1], s_vel_z};

    // op 3 wraps at the sum width
    assign msum_next = msum_reg + {s_mass[W-1], s_mass};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_px_reg <= '0; st_py_reg <= '0; st_pz_reg <= '0;
            st_vx_reg <= '0; st_vy_reg <= '0; st_vz_reg <= '0;
            st_m_reg  <= '0;
            msum_reg  <= '0;
            mok_reg   <= 1'b0;
        end else if (s_xfer) begin
            case (s_op)
                osma_pkg::OP_STORE_FIRST: begin
                    st_px_reg <= s_pos_x; st_py_reg <= s_pos_y; st_pz_reg <= s_pos_z;
                    st_vx_reg <= s_vel_x; st_vy_reg <= s_vel_y; st_vz_reg <= s_vel_z;
                    st_m_reg  <= s_mass;
                end
                osma_pkg::OP_OUTER_IN1: begin
                    msum_reg <= {s_mass[W-1], s_mass};
                    mok_reg  <= m_pos;
                end
                osma_pkg::OP_OUTER_IN2: begin
                    msum_reg <= msum_next;
                    mok_reg  <= mok_reg && m_pos;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // G*M, shift-add over the bits of G; finishes well inside the squares
    // ------------------------------------------------------------------
    assign sq_start = s_xfer && is_calc && !bad_mass;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm_busy_reg <= 1'b0;
        end else if (sq_start) begin
            gm_busy_reg <= 1'b1;
        end else if (gm_cnt_reg == osma_pkg::GCNT_W'(osma_pkg::REG_W - 1)) begin
            gm_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_start) begin
            gm_reg        <= '0;
            gm_mcand_reg  <= osma_pkg::GM_W'(mtot);
            gm_mplier_reg <= grav_reg;
            gm_cnt_reg    <= '0;
        end else if (gm_busy_reg) begin
            if (gm_mplier_reg[0]) begin
                gm_reg <= gm_reg + gm_mcand_reg;
            end
            gm_mcand_reg  <= {gm_mcand_reg[osma_pkg::GM_W-2:0], 1'b0};
            gm_mplier_reg <= {1'b0, gm_mplier_reg[osma_pkg::REG_W-1:1]};
            gm_cnt_reg    <= gm_cnt_reg + osma_pkg::GCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // serial units
    // ------------------------------------------------------------------
    osma_sqacc u_pos_sq (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .d0(dpx), .d1(dpy), .d2(dpz), .done(pos_done), .sum(sr_sum)
    );

    osma_sqacc u_vel_sq (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .d0(dvx), .d1(dvy), .d2(dvz), .done(vel_done), .sum(sv_sum)
    );

    assign rt_start = (state_reg == S_SQ) && pos_done;

    osma_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(rt_start),
        .radicand(sr_sum), .done(rt_done), .root(root)
    );

    // r == 0 is always too close
    assign too_close = (root == '0) ||
                       (root < osma_pkg::ROOT_W'(mindst_reg));

    // K = S_v / 2^(F+1); unbound when K + margin >= P
    assign k_ext   = osma_pkg::GM_W'(sv_sum[osma_pkg::SQ_W-1:osma_pkg::FRAC_BITS+1]);
    assign k_marg  = {1'b0, k_ext} + (osma_pkg::GM_W+1)'(margin_reg);
    assign unbound = (k_marg >= {1'b0, p_reg});

    assign dv_start   = ((state_reg == S_SQRT) && rt_done && !too_close) ||
                        ((state_reg == S_CMP) && !unbound);
    assign dv_divisor = (state_reg == S_SQRT) ? osma_pkg::GM_W'(root)
                                              : (p_reg - k_ext);

    osma_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(gm_reg), .divisor(dv_divisor),
        .busy(dv_busy), .done(dv_done), .quotient(quotient)
    );

    // a = floor(q / 2), saturated to the output width
    assign sma_next = (quotient[osma_pkg::GM_W-1:osma_pkg::OUT_W+1] != '0)
                    ? {osma_pkg::OUT_W{1'b1}}
                    : quotient[osma_pkg::OUT_W:1];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_xfer && is_calc) begin
                        state_reg <= bad_mass ? S_OUT : S_SQ;
                    end
                end
                S_SQ: begin
                    if (pos_done) begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (rt_done) begin
                        state_reg <= too_close ? S_OUT : S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (dv_done) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= unbound ? S_OUT : S_DIV2;
                end
                S_DIV2: begin
                    if (dv_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_IDLE) && s_xfer) begin
            status_reg <= osma_pkg::ST_BAD_MASS;
            sma_reg    <= '0;
        end else if ((state_reg == S_SQRT) && rt_done) begin
            status_reg <= osma_pkg::ST_TOO_CLOSE;
        end else if ((state_reg == S_DIV1) && dv_done) begin
            p_reg <= quotient;
        end else if (state_reg == S_CMP) begin
            status_reg <= osma_pkg::ST_UNBOUND;
        end else if ((state_reg == S_DIV2) && dv_done) begin
            status_reg <= osma_pkg::ST_OK;
            sma_reg    <= sma_next;
        end
    end

    // output register: a finished result waits here while new items enter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && !m_valid_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && !m_valid_reg) begin
            m_semi_major_axis <= sma_reg;
            m_status          <= status_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_sq_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_done == vel_done)
        else $error("position and velocity square sums out of step");

    a_gm_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_done |-> !gm_busy_reg)
        else $error("G*M not finished when the squares are");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_start |-> !dv_busy)
        else $error("divider restarted while busy");

    a_zero_unless_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == osma_pkg::ST_OK) || (m_semi_major_axis == '0))
        else $error("nonzero axis with a fault status");

    a_calc_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && is_calc |=> !s_ready)
        else $error("new item taken during a computation");

endmodule
